// ===== hdl/sle_pkg.sv =====
`timescale 1ns / 1ps

package sle_pkg;

    // list geometry
    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    // operation codes carried by the input word
    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_SEARCH = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_POP    = 2'd3
    } t_mode;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    // what each cell does on the update cycle
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_POP    = 2'd3
    } t_cell_op;

    // control broadcast along the row of cells
    typedef struct packed {
        logic     cmp_en;
        t_cell_op op;
    } t_cell_ctl;

endpackage

// ===== hdl/sle_if.sv =====
`timescale 1ns / 1ps

// operation channel
interface sle_in_if import sle_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic [1:0]                    mode;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

// result channel
interface sle_out_if import sle_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic signed [VALUE_WIDTH-1:0] popped_value;
    logic [CNT_W-1:0]              count;

    modport source (output valid, output status, output popped_value, output count,
                    input ready);
    modport sink   (input valid, input status, input popped_value, input count,
                    output ready);
endinterface

// ===== hdl/sle_cell.sv =====
`timescale 1ns / 1ps

// One slot of the sorted list. Compares its value against the broadcast key,
// then shifts left, shifts right or loads the key depending on the neighbours.
module sle_cell import sle_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cell_ctl                     i_ctl,
    input  logic signed [VALUE_WIDTH-1:0] i_key,
    input  logic signed [VALUE_WIDTH-1:0] i_left_val,
    input  logic                          i_left_occ,
    input  logic                          i_left_lt,
    input  logic signed [VALUE_WIDTH-1:0] i_right_val,
    input  logic                          i_right_occ,
    output logic signed [VALUE_WIDTH-1:0] o_val,
    output logic                          o_occ,
    output logic                          o_lt,
    output logic                          o_eq
);

    logic signed [VALUE_WIDTH-1:0] r_val, n_val;
    logic                          r_occ, n_occ;
    logic                          r_lt, r_eq;

    // next slot contents
    always_comb begin
        n_val = r_val;
        n_occ = r_occ;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (!r_lt) begin
                    if (i_left_lt) begin
                        n_val = i_key;
                        n_occ = 1'b1;
                    end else begin
                        n_val = i_left_val;
                        n_occ = i_left_occ;
                    end
                end
            end
            CELL_DELETE: begin
                if (!r_lt) begin
                    n_val = i_right_val;
                    n_occ = i_right_occ;
                end
            end
            CELL_POP: begin
                n_val = i_right_val;
                n_occ = i_right_occ;
            end
            default: begin
                n_val = r_val;
                n_occ = r_occ;
            end
        endcase
    end

    // slot value, no reset needed
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    // occupancy and compare flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
            r_lt  <= 1'b0;
            r_eq  <= 1'b0;
        end else begin
            r_occ <= n_occ;
            if (i_ctl.cmp_en) begin
                r_lt <= r_occ && (r_val < i_key);
                r_eq <= r_occ && (r_val == i_key);
            end
        end
    end

    assign o_val = r_val;
    assign o_occ = r_occ;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;

endmodule

// ===== hdl/sorted_list_engine_unit.sv =====
`timescale 1ns / 1ps

// Sorted list engine: keeps up to CAPACITY signed values in ascending order in a
// row of compare-and-shift cells. Each operation word (insert, search, delete
// first match, pop smallest) gives one result word with status, popped value
// and count. An operation has a compare step, where every cell compares its
// value with the key, and an update step, where the cells shift or load in
// parallel. The next word is taken in the same cycle as the update, so a new
// word waits for the previous update; a result is held in an output register
// and stalls the update cycle only if the previous result is not yet taken.
module sorted_list_engine_unit import sle_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sle_in_if.sink        i_in,
    sle_out_if.source     o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    t_state                        r_state;
    t_mode                         r_mode;
    logic signed [VALUE_WIDTH-1:0] r_key;
    logic [CNT_W-1:0]              r_count, n_count;
    logic                          r_out_valid;
    t_status                       r_status, n_status;
    logic signed [VALUE_WIDTH-1:0] r_popped, n_popped;

    t_cell_ctl                     cell_ctl;
    t_cell_op                      upd_op;
    logic signed [VALUE_WIDTH-1:0] cell_val [CAPACITY];
    logic [CAPACITY-1:0]           cell_occ, cell_lt, cell_eq;
    logic                          in_fire, upd_fire, found, full, empty;

    // handshake
    assign upd_fire    = (r_state == S_UPD) && (!r_out_valid || o_out.ready);
    assign i_in.ready  = (r_state == S_IDLE) || upd_fire;
    assign in_fire     = i_in.valid && i_in.ready;

    // outcome of the compare cycle
    assign found = |cell_eq;
    assign full  = (r_count == CNT_W'(CAPACITY));
    assign empty = (r_count == '0);

    always_comb begin
        upd_op   = CELL_HOLD;
        n_status = ST_OK;
        n_popped = '0;
        n_count  = r_count;
        case (r_mode)
            MODE_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    upd_op  = CELL_INSERT;
                    n_count = r_count + 1'b1;
                end
            end
            MODE_SEARCH: begin
                n_status = found ? ST_OK : ST_NOT_FOUND;
            end
            MODE_DELETE: begin
                if (found) begin
                    upd_op  = CELL_DELETE;
                    n_count = r_count - 1'b1;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            MODE_POP: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    upd_op   = CELL_POP;
                    n_popped = cell_val[0];
                    n_count  = r_count - 1'b1;
                end
            end
            default: begin
                upd_op = CELL_HOLD;
            end
        endcase
    end

    assign cell_ctl.cmp_en = (r_state == S_CMP);
    assign cell_ctl.op     = upd_fire ? upd_op : CELL_HOLD;

    // row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VALUE_WIDTH-1:0] left_val, right_val;
        logic                          left_occ, left_lt, right_occ;

        if (g == 0) begin : g_head
            assign left_val = r_key;
            assign left_occ = 1'b1;
            assign left_lt  = 1'b1;
        end else begin : g_mid
            assign left_val = cell_val[g-1];
            assign left_occ = cell_occ[g-1];
            assign left_lt  = cell_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_val = cell_val[g];
            assign right_occ = 1'b0;
        end else begin : g_body
            assign right_val = cell_val[g+1];
            assign right_occ = cell_occ[g+1];
        end

        sle_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (cell_ctl),
            .i_key       (r_key),
            .i_left_val  (left_val),
            .i_left_occ  (left_occ),
            .i_left_lt   (left_lt),
            .i_right_val (right_val),
            .i_right_occ (right_occ),
            .o_val       (cell_val[g]),
            .o_occ       (cell_occ[g]),
            .o_lt        (cell_lt[g]),
            .o_eq        (cell_eq[g])
        );
    end

    // sequencer, count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // new result loaded, or the held one taken
            if (upd_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (upd_fire) begin
                        r_count <= n_count;
                        r_state <= in_fire ? S_CMP : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        // payload, no reset
        if (in_fire) begin
            r_mode <= t_mode'(i_in.mode);
            r_key  <= i_in.value;
        end
        if (upd_fire) begin
            r_status <= n_status;
            r_popped <= n_popped;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_status;
    assign o_out.popped_value = r_popped;
    assign o_out.count        = r_count;

endmodule
